>>> src/pva_pkg.sv
// ---------------------------------------------------------------------------
// pva_pkg: shared types and constants for the priority voice allocator
// Voice pool size, field widths, operation and status codes, scan state.
// ---------------------------------------------------------------------------
package pva_pkg;

   localparam int VOICES = 8;
   localparam int IDX_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int CNT_W  = $clog2(VOICES + 1);
   localparam int LIM_W  = 4;
   localparam int CMP_W  = (CNT_W > LIM_W) ? CNT_W : LIM_W;
   localparam int MASK_W = 8;
   localparam int TAG_W  = 8;
   localparam int PRIO_W = 8;
   localparam int VOL_W  = 15;

   localparam int VOL_MIN = -10000;
   localparam int VOL_MAX = 0;
   localparam int MASTER_RESET = -2000;

   typedef enum logic [1:0] {
      OP_PLAY     = 2'd0,
      OP_FINISH   = 2'd1,
      OP_STOP_ALL = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      STATUS_STARTED  = 2'd0,
      STATUS_REJECTED = 2'd1,
      STATUS_CASCADE  = 2'd2,
      STATUS_FREED    = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_SWEEP,
      S_MISC,
      S_DONE
   } state_type;

   // one voice entry as seen by the scan step
   typedef struct packed {
      logic              busy;
      logic [TAG_W-1:0]  tag;
      logic [PRIO_W-1:0] prio;
      logic [IDX_W-1:0]  idx;
   } entry_type;

   // running result of the voice scan
   typedef struct packed {
      logic              idle_found;
      logic [IDX_W-1:0]  idle_idx;
      logic              victim_found;
      logic [IDX_W-1:0]  victim_idx;
      logic [PRIO_W-1:0] low_prio;
      logic [CNT_W-1:0]  count;
   } scan_acc_type;

   // stopped_mask bit of a voice; voices above the mask width have none
   function automatic logic [MASK_W-1:0] voice_bit(input logic [IDX_W-1:0] i);
      logic [MASK_W-1:0] b;
      b = '0;
      if (32'(i) < MASK_W) begin
         b = MASK_W'(1) << i;
      end
      return b;
   endfunction

endpackage

>>> src/pva_scan_step.sv
// ---------------------------------------------------------------------------
// pva_scan_step: one step of the voice scan
// Folds one voice entry into the running idle / victim / tag-count result
// and flags a busy voice holding the requested tag.
// ---------------------------------------------------------------------------
module pva_scan_step (
   input  pva_pkg::entry_type         entry,
   input  logic [pva_pkg::TAG_W-1:0]  req_tag,
   input  pva_pkg::scan_acc_type      acc_cur,
   output pva_pkg::scan_acc_type      acc_next,
   output logic                       tag_hit
);

   logic tag_eq;

   assign tag_eq  = (entry.tag == req_tag);
   assign tag_hit = entry.busy && tag_eq;

   always_comb begin
      acc_next = acc_cur;
      if (!entry.busy) begin
         if (!acc_cur.idle_found) begin
            acc_next.idle_found = 1'b1;
            acc_next.idle_idx   = entry.idx;
         end
      end else begin
         if (tag_eq) begin
            acc_next.count = acc_cur.count + pva_pkg::CNT_W'(1);
         end
         // ties go to the later voice
         if (entry.prio <= acc_cur.low_prio) begin
            acc_next.low_prio     = entry.prio;
            acc_next.victim_found = 1'b1;
            acc_next.victim_idx   = entry.idx;
         end
      end
   end

endmodule

>>> src/priority_voice_allocator_unit.sv
// ---------------------------------------------------------------------------
// priority_voice_allocator_unit: voice pool allocator with priority stealing
// Play, finish and stop-all requests against a pool of VOICES voices.
// ---------------------------------------------------------------------------
// Usage:
//   req_* is a valid/ready request channel; rsp_* returns exactly one result
//   per request on a valid/ready channel. csr_we/csr_wdata write the master
//   volume; write it only while the block is idle, which the block itself
//   does not enforce. A play request scans the voices one per cycle
//   through a single shared compare step. Its steps are capture, scan,
//   decide, then a sweep over the voices by tag when the cascade limit is
//   hit, then the load of the result register. Finish and stop-all go
//   through capture, the misc step and the result register load.
//   req_ready is high only while no request is in progress. A new request
//   may be taken while the previous result still waits on rsp_ready; it
//   holds in its last step until the result register is free.
//   Reset (synchronous, active high) frees all voices, sets master volume
//   to -2000 and drops rsp_valid.
// ---------------------------------------------------------------------------
module priority_voice_allocator_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_op,
   input  logic [pva_pkg::TAG_W-1:0]         req_tag_id,
   input  logic [pva_pkg::PRIO_W-1:0]        req_priority_req,
   input  logic [pva_pkg::LIM_W-1:0]         req_cascade_limit,
   input  logic signed [pva_pkg::VOL_W-1:0]  req_volume_offset,
   input  logic [2:0]                        req_finished_voice,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [1:0]                        rsp_status,
   output logic [2:0]                        rsp_voice,
   output logic                              rsp_stole,
   output logic [pva_pkg::MASK_W-1:0]        rsp_stopped_mask,
   output logic signed [pva_pkg::VOL_W-1:0]  rsp_voice_volume,
   input  logic                              csr_we,
   input  logic signed [pva_pkg::VOL_W-1:0]  csr_wdata
);

   localparam logic [pva_pkg::IDX_W-1:0] LAST_IDX = pva_pkg::IDX_W'(pva_pkg::VOICES - 1);

   // control state
   pva_pkg::state_type                 state_ff, state_in;
   logic [pva_pkg::VOICES-1:0]         busy_ff, busy_in;
   logic signed [pva_pkg::VOL_W-1:0]   master_ff, master_in;
   logic                               rsp_valid_ff, rsp_valid_in;

   // voice entries
   logic [pva_pkg::TAG_W-1:0]          tag_ff  [pva_pkg::VOICES];
   logic [pva_pkg::PRIO_W-1:0]         prio_ff [pva_pkg::VOICES];
   logic                               entry_we;
   logic [pva_pkg::IDX_W-1:0]          entry_wa;

   // captured request
   logic [1:0]                         op_ff, op_in;
   logic [pva_pkg::TAG_W-1:0]          rtag_ff, rtag_in;
   logic [pva_pkg::PRIO_W-1:0]         rprio_ff, rprio_in;
   logic [pva_pkg::LIM_W-1:0]          limit_ff, limit_in;
   logic signed [pva_pkg::VOL_W-1:0]   offset_ff, offset_in;
   logic [2:0]                         fin_ff, fin_in;

   // sequencer datapath
   logic [pva_pkg::IDX_W-1:0]          idx_ff, idx_in;
   pva_pkg::scan_acc_type              acc_ff, acc_in, acc_step;
   pva_pkg::entry_type                 entry;
   logic                               tag_hit;

   // pending result
   pva_pkg::status_type                res_status_ff, res_status_in;
   logic [2:0]                         res_voice_ff, res_voice_in;
   logic                               res_stole_ff, res_stole_in;
   logic [pva_pkg::MASK_W-1:0]         res_mask_ff, res_mask_in;
   logic signed [pva_pkg::VOL_W-1:0]   res_vol_ff, res_vol_in;

   // output register
   pva_pkg::status_type                rsp_status_ff, rsp_status_in;
   logic [2:0]                         rsp_voice_ff, rsp_voice_in;
   logic                               rsp_stole_ff, rsp_stole_in;
   logic [pva_pkg::MASK_W-1:0]         rsp_mask_ff, rsp_mask_in;
   logic signed [pva_pkg::VOL_W-1:0]   rsp_vol_ff, rsp_vol_in;

   // decide helpers
   logic                               cascade_hit;
   logic                               steal;
   logic [pva_pkg::IDX_W-1:0]          chosen;
   logic signed [pva_pkg::VOL_W:0]     vol_sum;
   logic signed [pva_pkg::VOL_W-1:0]   vol_clamped;
   logic [pva_pkg::IDX_W-1:0]          fin_idx;
   logic [pva_pkg::VOICES+pva_pkg::MASK_W-1:0] busy_wide;

   assign entry.busy = busy_ff[idx_ff];
   assign entry.tag  = tag_ff[idx_ff];
   assign entry.prio = prio_ff[idx_ff];
   assign entry.idx  = idx_ff;

   pva_scan_step u_scan_step (
      .entry    (entry),
      .req_tag  (rtag_ff),
      .acc_cur  (acc_ff),
      .acc_next (acc_step),
      .tag_hit  (tag_hit)
   );

   assign cascade_hit = pva_pkg::CMP_W'(acc_ff.count) >= pva_pkg::CMP_W'(limit_ff);
   assign steal       = !acc_ff.idle_found;
   assign chosen      = acc_ff.idle_found ? acc_ff.idle_idx : acc_ff.victim_idx;
   assign vol_sum     = (pva_pkg::VOL_W+1)'(master_ff) + (pva_pkg::VOL_W+1)'(offset_ff);
   assign fin_idx     = pva_pkg::IDX_W'(fin_ff);
   assign busy_wide   = (pva_pkg::VOICES+pva_pkg::MASK_W)'(busy_ff);

   always_comb begin
      if (vol_sum < (pva_pkg::VOL_W+1)'(pva_pkg::VOL_MIN)) begin
         vol_clamped = pva_pkg::VOL_W'(pva_pkg::VOL_MIN);
      end else if (vol_sum > (pva_pkg::VOL_W+1)'(pva_pkg::VOL_MAX)) begin
         vol_clamped = pva_pkg::VOL_W'(pva_pkg::VOL_MAX);
      end else begin
         vol_clamped = pva_pkg::VOL_W'(vol_sum);
      end
   end

   assign req_ready = (state_ff == pva_pkg::S_IDLE);

   always_comb begin
      state_in      = state_ff;
      busy_in       = busy_ff;
      master_in     = csr_we ? csr_wdata : master_ff;
      rsp_valid_in  = rsp_valid_ff;
      entry_we      = 1'b0;
      entry_wa      = chosen;
      op_in         = op_ff;
      rtag_in       = rtag_ff;
      rprio_in      = rprio_ff;
      limit_in      = limit_ff;
      offset_in     = offset_ff;
      fin_in        = fin_ff;
      idx_in        = idx_ff;
      acc_in        = acc_ff;
      res_status_in = res_status_ff;
      res_voice_in  = res_voice_ff;
      res_stole_in  = res_stole_ff;
      res_mask_in   = res_mask_ff;
      res_vol_in    = res_vol_ff;
      rsp_status_in = rsp_status_ff;
      rsp_voice_in  = rsp_voice_ff;
      rsp_stole_in  = rsp_stole_ff;
      rsp_mask_in   = rsp_mask_ff;
      rsp_vol_in    = rsp_vol_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         pva_pkg::S_IDLE: begin
            if (req_valid) begin
               op_in     = req_op;
               rtag_in   = req_tag_id;
               rprio_in  = req_priority_req;
               limit_in  = req_cascade_limit;
               offset_in = req_volume_offset;
               fin_in    = req_finished_voice;
               idx_in    = '0;
               acc_in    = '0;
               acc_in.low_prio = req_priority_req;
               res_status_in = pva_pkg::STATUS_FREED;
               res_voice_in  = '0;
               res_stole_in  = 1'b0;
               res_mask_in   = '0;
               res_vol_in    = '0;
               state_in = (req_op == pva_pkg::OP_PLAY) ? pva_pkg::S_SCAN : pva_pkg::S_MISC;
            end
         end

         pva_pkg::S_SCAN: begin
            acc_in = acc_step;
            idx_in = idx_ff + pva_pkg::IDX_W'(1);
            if (idx_ff == LAST_IDX) begin
               state_in = pva_pkg::S_DECIDE;
            end
         end

         pva_pkg::S_DECIDE: begin
            state_in = pva_pkg::S_DONE;
            if (steal && !acc_ff.victim_found) begin
               res_status_in = pva_pkg::STATUS_REJECTED;
            end else begin
               res_stole_in = steal;
               if (steal) begin
                  busy_in[acc_ff.victim_idx] = 1'b0;
                  res_mask_in = pva_pkg::voice_bit(acc_ff.victim_idx);
               end
               if (cascade_hit) begin
                  res_status_in = pva_pkg::STATUS_CASCADE;
                  res_voice_in  = steal ? 3'(chosen) : 3'd0;
                  idx_in        = '0;
                  state_in      = pva_pkg::S_SWEEP;
               end else begin
                  busy_in[chosen] = 1'b1;
                  entry_we        = 1'b1;
                  res_status_in   = pva_pkg::STATUS_STARTED;
                  res_voice_in    = 3'(chosen);
                  res_vol_in      = vol_clamped;
               end
            end
         end

         pva_pkg::S_SWEEP: begin
            // stop every busy voice still holding the tag
            if (tag_hit) begin
               busy_in[idx_ff] = 1'b0;
               res_mask_in = res_mask_ff | pva_pkg::voice_bit(idx_ff);
            end
            idx_in = idx_ff + pva_pkg::IDX_W'(1);
            if (idx_ff == LAST_IDX) begin
               state_in = pva_pkg::S_DONE;
            end
         end

         pva_pkg::S_MISC: begin
            state_in = pva_pkg::S_DONE;
            case (op_ff)
               pva_pkg::OP_FINISH: begin
                  if ((32'(fin_ff) < pva_pkg::VOICES) && busy_ff[fin_idx]) begin
                     busy_in[fin_idx] = 1'b0;
                     res_mask_in = pva_pkg::voice_bit(fin_idx);
                  end
               end
               pva_pkg::OP_STOP_ALL: begin
                  res_mask_in = busy_wide[pva_pkg::MASK_W-1:0];
                  busy_in     = '0;
               end
               default: begin
               end
            endcase
         end

         pva_pkg::S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_voice_in  = res_voice_ff;
               rsp_stole_in  = res_stole_ff;
               rsp_mask_in   = res_mask_ff;
               rsp_vol_in    = res_vol_ff;
               state_in      = pva_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = pva_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pva_pkg::S_IDLE;
         busy_ff      <= '0;
         master_ff    <= pva_pkg::VOL_W'(pva_pkg::MASTER_RESET);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= busy_in;
         master_ff    <= master_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      rtag_ff       <= rtag_in;
      rprio_ff      <= rprio_in;
      limit_ff      <= limit_in;
      offset_ff     <= offset_in;
      fin_ff        <= fin_in;
      idx_ff        <= idx_in;
      acc_ff        <= acc_in;
      res_status_ff <= res_status_in;
      res_voice_ff  <= res_voice_in;
      res_stole_ff  <= res_stole_in;
      res_mask_ff   <= res_mask_in;
      res_vol_ff    <= res_vol_in;
      rsp_status_ff <= rsp_status_in;
      rsp_voice_ff  <= rsp_voice_in;
      rsp_stole_ff  <= rsp_stole_in;
      rsp_mask_ff   <= rsp_mask_in;
      rsp_vol_ff    <= rsp_vol_in;
      if (entry_we) begin
         tag_ff[entry_wa]  <= rtag_ff;
         prio_ff[entry_wa] <= rprio_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_voice        = rsp_voice_ff;
   assign rsp_stole        = rsp_stole_ff;
   assign rsp_stopped_mask = rsp_mask_ff;
   assign rsp_voice_volume = rsp_vol_ff;

endmodule
